/* src/buck_voltage_pid_loop_defines.svh */
// ---------------------------------------------------------------------------
// Buck voltage PID loop assertion macros
// Concurrent assertion helpers that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BUCK_VOLTAGE_PID_LOOP_DEFINES_SVH
`define BUCK_VOLTAGE_PID_LOOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BVPL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define BVPL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define BVPL_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BVPL_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* src/bvpl_pkg.sv */
// ---------------------------------------------------------------------------
// Buck voltage PID loop package
// Payload, configuration and command types shared by the loop modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bvpl_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int ERR_W       = 18;
    localparam int ACC_W       = 32;
    localparam int MUL_A_W     = 19;
    localparam int MUL_B_W     = 17;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_CAL_GAIN   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAL_OFFSET = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DUTY   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_DUTY   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PWM_PERIOD = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BOOST_DUTY = 3'd5;

    localparam logic        [15:0] RST_CAL_GAIN   = 16'd4096;
    localparam logic signed [12:0] RST_CAL_OFFSET = 13'sd0;
    localparam logic        [11:0] RST_MAX_DUTY   = 12'd3686;
    localparam logic        [11:0] RST_MIN_DUTY   = 12'd82;
    localparam logic        [15:0] RST_PWM_PERIOD = 16'd46080;
    localparam logic        [11:0] RST_BOOST_DUTY = 12'd3809;

    localparam logic signed [15:0] COEF_B0 = 16'sd5203;
    localparam logic signed [15:0] COEF_B1 = -16'sd10246;
    localparam logic signed [15:0] COEF_B2 = 16'sd5044;

    typedef struct packed {
        logic [11:0] voltage_sample;
        logic [12:0] voltage_target;
        logic        drive_enable;
    } in_t;

    typedef struct packed {
        logic [11:0] buck_duty;
        logic [15:0] buck_compare;
        logic [14:0] sample_trigger_compare;
        logic [15:0] boost_compare;
    } out_t;

    typedef struct packed {
        logic        [15:0] cal_gain;
        logic signed [12:0] cal_offset;
        logic        [11:0] max_duty;
        logic        [11:0] min_duty;
        logic        [15:0] pwm_period;
        logic        [11:0] boost_duty;
    } cfg_t;

    typedef enum logic [2:0] {
        MUL_CAL,
        MUL_B0,
        MUL_B1,
        MUL_B2,
        MUL_BUCK,
        MUL_BOOST
    } mul_sel_t;

    typedef struct packed {
        logic     in_load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     err_load;
        logic     acc_add;
        logic     hist_load;
        logic     duty_load;
        logic     bcmp_load;
        logic     out_load;
    } cmd_t;

endpackage

`default_nettype wire

/* src/buck_voltage_pid_loop.sv */
// ---------------------------------------------------------------------------
// Buck voltage PID loop
// Calibrates each output-voltage sample, runs an incremental PID update and
// produces the clamped buck duty with the buck, trigger and boost compares.
//
// The input channel takes one sample with its target and drive enable per
// transfer; the output channel returns one result per sample. Both channels
// use valid and ready. The config channel is always ready and writes one
// register per transfer; the user must write it only while no sample is in
// flight, as the block itself does not enforce this. A new sample is taken
// once the previous one has been moved to the output register, so the block
// does not take a new sample while one is in flight. The pace is set by the
// single shared multiplier, used six times per sample by the controller.
// The output register holds a finished result while the receiver stalls; the
// next sample is still taken and computed, and waits in its final step until
// the output register is free. Reset clears the error history and the
// accumulator and loads the default register values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "buck_voltage_pid_loop_defines.svh"

module buck_voltage_pid_loop (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire bvpl_pkg::in_t                    in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output bvpl_pkg::out_t                        out_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bvpl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bvpl_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bvpl_pkg::*;

    cfg_t cfg;
    cmd_t cmd;

    bvpl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bvpl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    bvpl_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .in_data  (in_data),
        .out_data (out_data)
    );

    `BVPL_ASSERT_NXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)
    `BVPL_ASSERT_IMP(a_no_overwrite, clk, rst_n, out_valid && !out_ready, !cmd.out_load)
    `BVPL_ASSERT_NXT(a_load_shows, clk, rst_n, cmd.out_load, out_valid)

endmodule

`default_nettype wire

/* src/bvpl_cfg.sv */
// ---------------------------------------------------------------------------
// Buck voltage PID loop configuration registers
// Holds the calibration, clamp and timer settings written over the config port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bvpl_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [bvpl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bvpl_pkg::CFG_DATA_W-1:0]  cfg_data,
    output bvpl_pkg::cfg_t                       cfg
);
    import bvpl_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CAL_GAIN:   cfg_next.cal_gain   = cfg_data;
                CFG_CAL_OFFSET: cfg_next.cal_offset = signed'(cfg_data[12:0]);
                CFG_MAX_DUTY:   cfg_next.max_duty   = cfg_data[11:0];
                CFG_MIN_DUTY:   cfg_next.min_duty   = cfg_data[11:0];
                CFG_PWM_PERIOD: cfg_next.pwm_period = cfg_data;
                CFG_BOOST_DUTY: cfg_next.boost_duty = cfg_data[11:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cal_gain   <= RST_CAL_GAIN;
            cfg_reg.cal_offset <= RST_CAL_OFFSET;
            cfg_reg.max_duty   <= RST_MAX_DUTY;
            cfg_reg.min_duty   <= RST_MIN_DUTY;
            cfg_reg.pwm_period <= RST_PWM_PERIOD;
            cfg_reg.boost_duty <= RST_BOOST_DUTY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* src/bvpl_ctrl.sv */
// ---------------------------------------------------------------------------
// Buck voltage PID loop controller
// Sequences the shared multiplier and the datapath steps for one sample.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bvpl_ctrl (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    output bvpl_pkg::cmd_t cmd
);
    import bvpl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CAL,
        S_ERR,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_DUTY,
        S_MBK,
        S_MBO,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = MUL_CAL;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = S_CAL;
                end
            end
            S_CAL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_CAL;
                state_next  = S_ERR;
            end
            S_ERR:
            begin
                cmd.err_load = 1'b1;
                state_next   = S_M0;
            end
            S_M0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_B0;
                state_next  = S_M1;
            end
            S_M1:
            begin
                cmd.acc_add = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_B1;
                state_next  = S_M2;
            end
            S_M2:
            begin
                cmd.acc_add = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_B2;
                state_next  = S_M3;
            end
            S_M3:
            begin
                cmd.acc_add = 1'b1;
                state_next  = S_DUTY;
            end
            S_DUTY:
            begin
                cmd.duty_load = 1'b1;
                cmd.hist_load = 1'b1;
                state_next    = S_MBK;
            end
            S_MBK:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_BUCK;
                state_next  = S_MBO;
            end
            S_MBO:
            begin
                cmd.bcmp_load = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_BOOST;
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* src/bvpl_dp.sv */
// ---------------------------------------------------------------------------
// Buck voltage PID loop datapath
// Shared multiplier, error history, PID accumulator, duty clamp and compares.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bvpl_dp (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire bvpl_pkg::cmd_t cmd,
    input  wire bvpl_pkg::cfg_t cfg,
    input  wire bvpl_pkg::in_t  in_data,
    output bvpl_pkg::out_t out_data
);
    import bvpl_pkg::*;

    in_t                      in_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ERR_W-1:0]  e0_reg;
    logic signed [ERR_W-1:0]  e1_reg;
    logic signed [ERR_W-1:0]  e2_reg;
    logic        [ACC_W-1:0]  acc_reg;
    logic        [11:0]       duty_reg;
    logic        [15:0]       bcmp_reg;
    out_t                     out_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [ERR_W-1:0]   cal_value;
    logic signed [ERR_W-1:0]   e0_next;
    logic signed [23:0]        duty_wide;
    logic signed [23:0]        max_wide;
    logic signed [23:0]        min_wide;
    logic        [11:0]        duty_next;
    logic        [15:0]        boost_next;

    assign out_data = out_reg;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_CAL:
            begin
                mul_a = signed'({7'd0, in_reg.voltage_sample});
                mul_b = signed'({1'b0, cfg.cal_gain});
            end
            MUL_B0:
            begin
                mul_a = {e0_reg[ERR_W-1], e0_reg};
                mul_b = {COEF_B0[15], COEF_B0};
            end
            MUL_B1:
            begin
                mul_a = {e1_reg[ERR_W-1], e1_reg};
                mul_b = {COEF_B1[15], COEF_B1};
            end
            MUL_B2:
            begin
                mul_a = {e2_reg[ERR_W-1], e2_reg};
                mul_b = {COEF_B2[15], COEF_B2};
            end
            MUL_BUCK:
            begin
                mul_a = signed'({7'd0, duty_reg});
                mul_b = signed'({1'b0, cfg.pwm_period});
            end
            MUL_BOOST:
            begin
                mul_a = signed'({7'd0, cfg.boost_duty});
                mul_b = signed'({1'b0, cfg.pwm_period});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        cal_value = signed'({2'b00, prod_reg[27:12]})
                  + {{(ERR_W-13){cfg.cal_offset[12]}}, cfg.cal_offset};
        e0_next   = signed'({5'd0, in_reg.voltage_target}) - cal_value;
    end

    always_comb
    begin
        max_wide  = signed'({12'd0, cfg.max_duty});
        min_wide  = signed'({12'd0, cfg.min_duty});
        duty_wide = signed'(acc_reg[31:8]);
        if (duty_wide > max_wide)
        begin
            duty_wide = max_wide;
        end
        if (duty_wide < min_wide)
        begin
            duty_wide = min_wide;
        end
        if (!in_reg.drive_enable)
        begin
            duty_wide = min_wide;
        end
        duty_next = duty_wide[11:0];
    end

    assign boost_next = cfg.pwm_period - prod_reg[27:12];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_reg  <= '0;
            e2_reg  <= '0;
            acc_reg <= '0;
        end
        else
        begin
            if (cmd.acc_add)
            begin
                acc_reg <= acc_reg + prod_reg[ACC_W-1:0];
            end
            if (cmd.hist_load)
            begin
                e2_reg <= e1_reg;
                e1_reg <= e0_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            in_reg <= in_data;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.err_load)
        begin
            e0_reg <= e0_next;
        end
        if (cmd.duty_load)
        begin
            duty_reg <= duty_next;
        end
        if (cmd.bcmp_load)
        begin
            bcmp_reg <= prod_reg[27:12];
        end
        if (cmd.out_load)
        begin
            out_reg.buck_duty              <= duty_reg;
            out_reg.buck_compare           <= bcmp_reg;
            out_reg.sample_trigger_compare <= bcmp_reg[15:1];
            out_reg.boost_compare          <= boost_next;
        end
    end

endmodule

`default_nettype wire
